// File: src/u8u16_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] Replacement = 16'd63;  // '?'

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'he0;
  localparam logic [7:0] Lead2Code  = 8'hc0;
  localparam logic [7:0] Lead3Mask  = 8'hf0;
  localparam logic [7:0] Lead3Code  = 8'he0;

  localparam logic [1:0] DueNone = 2'd0;
  localparam logic [1:0] DueOne  = 2'd1;
  localparam logic [1:0] DueTwo  = 2'd2;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_end;
  } result_t;

endpackage

// File: src/utf8_to_utf16_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// Decodes a UTF-8 byte stream (BMP only) into 16-bit UTF-16 code units.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-----------------------------------
//   in      | in  | in_valid_i/in_ready_o | in_byte_i, string_last_i
//   out     | out | out_valid_o/out_ready_i | code_unit_o, run_last_o,
//           |     |                       | string_end_o
//
// One byte per cycle while in_ready_o is high; decode is a single pass from
// the accepted byte into the output register. A byte that yields two words
// (string ends after one follower of a 3-byte sequence) stalls the input
// while the second word sits in a spare register. Bytes absorbed into a
// sequence yield no word. Reset clears the sequence state and both valid
// flags. Output stalls reach in_ready_o only when the output register is full.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder
  import u8u16_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        string_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] code_unit_o,
  output logic        run_last_o,
  output logic        string_end_o
);

  logic [1:0] due_q, due_d;
  logic [9:0] part_q, part_d;

  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;
  logic    pend_valid_q, pend_valid_d;
  result_t pend_q, pend_d;

  logic    in_fire;
  logic    out_free;
  logic    dec_n0, dec_n1;   // first / second word produced
  result_t dec_r0, dec_r1;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !pend_valid_q && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // decode of one byte against the pending sequence
  always_comb begin
    due_d  = due_q;
    part_d = part_q;
    dec_n0 = 1'b0;
    dec_n1 = 1'b0;
    dec_r0 = '{code_unit: Replacement, run_last: 1'b1, string_end: string_last_i};
    dec_r1 = '{code_unit: Replacement, run_last: 1'b1, string_end: string_last_i};

    case (due_q)
      DueOne: begin
        dec_n0           = 1'b1;
        dec_r0.code_unit = {part_q, in_byte_i[5:0]};
        due_d            = DueNone;
        part_d           = '0;
      end
      DueTwo: begin
        if (string_last_i) begin
          // lead becomes '?', follower decoded on its own
          dec_n0            = 1'b1;
          dec_n1            = 1'b1;
          dec_r0.run_last   = 1'b0;
          dec_r0.string_end = 1'b0;
          if (in_byte_i < AsciiLimit) begin
            dec_r1.code_unit = {8'd0, in_byte_i};
          end
          due_d  = DueNone;
          part_d = '0;
        end else begin
          part_d = {part_q[3:0], in_byte_i[5:0]};
          due_d  = DueOne;
        end
      end
      default: begin
        due_d  = DueNone;
        part_d = '0;
        if (in_byte_i < AsciiLimit) begin
          dec_n0           = 1'b1;
          dec_r0.code_unit = {8'd0, in_byte_i};
        end else if ((in_byte_i & Lead2Mask) == Lead2Code && !string_last_i) begin
          part_d = {5'd0, in_byte_i[4:0]};
          due_d  = DueOne;
        end else if ((in_byte_i & Lead3Mask) == Lead3Code && !string_last_i) begin
          part_d = {6'd0, in_byte_i[3:0]};
          due_d  = DueTwo;
        end else begin
          dec_n0 = 1'b1;
        end
      end
    endcase

    if (string_last_i) begin
      due_d  = DueNone;
      part_d = '0;
    end
  end

  // output register plus spare slot for a second word
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d  = pend_valid_q;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end

    if (in_fire) begin
      out_valid_d  = dec_n0;
      out_d        = dec_r0;
      pend_valid_d = dec_n1;
      pend_d       = dec_r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      due_q        <= DueNone;
      part_q       <= '0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        due_q  <= due_d;
        part_q <= part_d;
      end
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o  = out_valid_q;
  assign code_unit_o  = out_q.code_unit;
  assign run_last_o   = out_q.run_last;
  assign string_end_o = out_q.string_end;

endmodule

// File: sim/tb_utf8_to_utf16_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_stream_decoder
// Self-checking bench for the UTF-8 to UTF-16 stream decoder. Directed strings
// cover ASCII, 2- and 3-byte sequences, bad leads and truncated strings; then
// random strings, mostly well-formed, run under four idle/stall patterns.
// Every output word is checked against a local decode model.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_stream_decoder
  import u8u16_pkg::*;
();

  localparam int StallLimit = 2000;
  localparam int TailCycles = 10;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i     = 8'h00;
  logic        string_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b1;
  logic [15:0] code_unit_o;
  logic        run_last_o;
  logic        string_end_o;

  utf8_to_utf16_stream_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .string_last_i (string_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_unit_o   (code_unit_o),
    .run_last_o    (run_last_o),
    .string_end_o  (string_end_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // decode model state
  logic [1:0] seq_due  = DueNone;
  logic [9:0] seq_bits = '0;
  result_t    expected_words[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int bytes_sent     = 0;
  int words_checked  = 0;
  int strings_done   = 0;
  int stall_cycles   = 0;

  function automatic void predict_words(input logic [7:0] b, input logic last);
    result_t words[2];
    int      n;
    n = 0;
    case (seq_due)
      DueOne: begin
        words[n].code_unit = {seq_bits, b[5:0]};
        n++;
        seq_due  = DueNone;
        seq_bits = '0;
      end
      DueTwo: begin
        if (last) begin
          words[n].code_unit = Replacement;
          n++;
          words[n].code_unit = (b < AsciiLimit) ? {8'h00, b} : Replacement;
          n++;
          seq_due  = DueNone;
          seq_bits = '0;
        end else begin
          seq_bits = {seq_bits[3:0], b[5:0]};
          seq_due  = DueOne;
        end
      end
      default: begin
        // pending count three is never reached; same as none pending
        seq_due  = DueNone;
        seq_bits = '0;
        if (b < AsciiLimit) begin
          words[n].code_unit = {8'h00, b};
          n++;
        end else if ((b & Lead2Mask) == Lead2Code && !last) begin
          seq_bits = {5'b0, b[4:0]};
          seq_due  = DueOne;
        end else if ((b & Lead3Mask) == Lead3Code && !last) begin
          seq_bits = {6'b0, b[3:0]};
          seq_due  = DueTwo;
        end else begin
          words[n].code_unit = Replacement;
          n++;
        end
      end
    endcase
    if (last) begin
      seq_due  = DueNone;
      seq_bits = '0;
    end
    for (int i = 0; i < n; i++) begin
      words[i].run_last   = (i == n - 1);
      words[i].string_end = (i == n - 1) && last;
      expected_words = {expected_words, words[i]};
    end
  endfunction

  // receiver: random back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: check output word first, then predict from accepted input byte
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: code_unit %h run_last %b string_end %b",
                 code_unit_o, run_last_o, string_end_o);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          words_checked++;
          if (string_end_o) strings_done++;
          if (code_unit_o !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, code_unit_o);
            fail_count++;
          end
          if (run_last_o !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, run_last_o);
            fail_count++;
          end
          if (string_end_o !== want.string_end) begin
            $error("string_end: expected %b, got %b", want.string_end, string_end_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_words(in_byte_i, string_last_i);
        bytes_sent++;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
      else stall_cycles++;
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("simulation failed");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i    <= 1'b1;
    in_byte_i     <= b;
    string_last_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_string(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_ascii();
    send_string('{8'h00});
    send_string('{8'h7f, 8'h41});
  endtask

  task automatic test_two_byte();
    send_string('{8'hc2, 8'ha9, 8'hdf, 8'hbf});
    // overlong form and a follower that is not a continuation byte
    send_string('{8'hc0, 8'h80, 8'hc3, 8'h41});
  endtask

  task automatic test_three_byte();
    send_string('{8'he2, 8'h82, 8'hac, 8'hef, 8'hbf, 8'hbf});
    send_string('{8'he0, 8'h80, 8'h80, 8'hed, 8'h00, 8'hff});
  endtask

  task automatic test_bad_leads();
    // a 4-byte lead, a 5-byte lead, 0xff and stray continuation bytes
    send_string('{8'hf0, 8'hf8, 8'hff, 8'h80, 8'hbf});
  endtask

  task automatic test_truncated();
    send_string('{8'hc3});
    send_string('{8'he2});
    send_string('{8'he2, 8'h82});  // two replacement words
    send_string('{8'he2, 8'h41});  // replacement, then 'A'
  endtask

  task automatic send_random_string();
    logic [7:0] bytes[$];
    int         n_chars;
    int         kind;
    n_chars = $urandom_range(1, 12);
    for (int c = 0; c < n_chars; c++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        bytes = {bytes, 8'($urandom_range(0, 127))};
      end else if (kind < 55) begin
        bytes = {bytes, {3'b110, 5'($urandom)}};
        bytes = {bytes, {2'b10, 6'($urandom)}};
      end else if (kind < 75) begin
        bytes = {bytes, {4'b1110, 4'($urandom)}};
        bytes = {bytes, {2'b10, 6'($urandom)}};
        bytes = {bytes, {2'b10, 6'($urandom)}};
      end else if (kind < 85) begin
        bytes = {bytes, 8'($urandom)};
      end else begin
        // possibly broken sequence: lead with at most one follower, any byte as follower
        if ($urandom_range(1)) bytes = {bytes, {3'b110, 5'($urandom)}};
        else bytes = {bytes, {4'b1110, 4'($urandom)}};
        if ($urandom_range(1)) bytes = {bytes, 8'($urandom)};
      end
    end
    send_string(bytes);
  endtask

  task automatic test_random();
    int idle_pattern[4][2] = '{'{0, 0}, '{52, 0}, '{0, 52}, '{27, 27}};
    int target;
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_pattern[p][0];
      recv_stall_pct = idle_pattern[p][1];
      target = bytes_sent + 250;
      while (bytes_sent < target) send_random_string();
      wait_drained();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ascii();
    test_two_byte();
    test_three_byte();
    test_bad_leads();
    test_truncated();
    wait_drained();
    test_random();
    repeat (TailCycles) @(posedge clk_i);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      fail_count++;
    end
    $display("run: %0d bytes in, %0d words checked, %0d strings closed",
             bytes_sent, words_checked, strings_done);
    $display("run: directed edge cases, then random strings under four idle patterns");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
